@@ rtl/core/pcich_pkg.sv @@
// Shared types, codes and sizes for the per-cell intensity class histogram.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pcich_pkg;

    // Storage sizes.
    localparam int NUM_CELLS     = 65536;
    localparam int CELL_AW       = $clog2(NUM_CELLS);
    localparam int COUNT_W       = 16;
    localparam int MAX_SCENARIOS = 256;
    localparam int SCN_AW        = $clog2(MAX_SCENARIOS);
    localparam int SCN_CW        = $clog2(MAX_SCENARIOS + 1);

    // Field widths.
    localparam int INT_W  = 20;
    localparam int CELL_W = 16;
    localparam int SIZE_W = 32;

    // Configuration port.
    localparam int REG_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [2:0] REG_MIN_INT  = 3'd0;
    localparam logic [2:0] REG_LOW_TOP  = 3'd1;
    localparam logic [2:0] REG_MED_TOP  = 3'd2;
    localparam logic [2:0] REG_MAX_INT  = 3'd3;
    localparam logic [2:0] REG_REC_BAND = 3'd4;

    // Item commands.
    localparam logic CMD_CELL = 1'b0;
    localparam logic CMD_SCN  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OOB  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Band codes.
    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MED  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;
    localparam logic [1:0] BAND_NONE = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [CELL_W-1:0] cell_index;
        logic [INT_W-1:0]  intensity;
        logic [SIZE_W-1:0] fire_size;
    } pcich_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         band;
        logic [COUNT_W-1:0] cell_total;
        logic [COUNT_W-1:0] band_count;
        logic [SCN_CW-1:0]  scenario_count;
        logic [SCN_AW-1:0]  size_rank;
    } pcich_out_t;

    typedef struct packed {
        logic [INT_W-1:0] min_intensity;
        logic [INT_W-1:0] low_band_top;
        logic [INT_W-1:0] med_band_top;
        logic [INT_W-1:0] max_intensity;
        logic             record_bands;
    } pcich_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic cell_rd;
        logic cell_wr;
        logic scn_full;
        logic ins_read;
        logic ins_shift;
        logic ins_put;
        logic out_load;
    } pcich_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_scn;
        logic list_full;
        logic at_zero;
        logic found;
        logic out_free;
    } pcich_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/pcich_regs.sv @@
// APB-style configuration registers for the intensity class histogram.
// Depends on pcich_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module pcich_regs
    import pcich_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [REG_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output pcich_cfg_t             cfg
);

    pcich_cfg_t  cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_intensity <= INT_W'(0);
            cfg_reg.low_band_top  <= INT_W'(2000);
            cfg_reg.med_band_top  <= INT_W'(4000);
            cfg_reg.max_intensity <= INT_W'(1048575);
            cfg_reg.record_bands  <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_INT:  cfg_reg.min_intensity <= pwdata[INT_W-1:0];
                REG_LOW_TOP:  cfg_reg.low_band_top  <= pwdata[INT_W-1:0];
                REG_MED_TOP:  cfg_reg.med_band_top  <= pwdata[INT_W-1:0];
                REG_MAX_INT:  cfg_reg.max_intensity <= pwdata[INT_W-1:0];
                REG_REC_BAND: cfg_reg.record_bands  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended.
    always_comb begin
        unique case (reg_idx)
            REG_MIN_INT:  prdata = APB_DW'(cfg_reg.min_intensity);
            REG_LOW_TOP:  prdata = APB_DW'(cfg_reg.low_band_top);
            REG_MED_TOP:  prdata = APB_DW'(cfg_reg.med_band_top);
            REG_MAX_INT:  prdata = APB_DW'(cfg_reg.max_intensity);
            REG_REC_BAND: prdata = APB_DW'(cfg_reg.record_bands);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pcich_ctrl.sv @@
// Sequencing controller for the intensity class histogram.
// Depends on pcich_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module pcich_ctrl
    import pcich_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire pcich_sts_t sts,
    output pcich_cmd_t      cmd
);

    localparam logic [2:0] ST_CLR     = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_DISP    = 3'd2;
    localparam logic [2:0] ST_CELL_WR = 3'd3;
    localparam logic [2:0] ST_INS_RD  = 3'd4;
    localparam logic [2:0] ST_INS_CMP = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts.is_scn && sts.list_full) begin
                    cmd.scn_full = 1'b1;
                    state_next   = ST_FIN;
                end else if (sts.is_scn) begin
                    state_next = ST_INS_RD;
                end else begin
                    cmd.cell_rd = 1'b1;
                    state_next  = ST_CELL_WR;
                end
            end
            ST_CELL_WR: begin
                cmd.cell_wr = 1'b1;
                state_next  = ST_FIN;
            end
            ST_INS_RD: begin
                if (sts.at_zero) begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    cmd.ins_read = 1'b1;
                    state_next   = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (sts.found) begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_RD;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pcich_dp.sv @@
// Datapath of the intensity class histogram: counter memories, sorted size
// list, band classification and the output register. Depends on pcich_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcich_dp
    import pcich_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pcich_in_t  s_data,
    input  wire pcich_cfg_t cfg,
    input  wire pcich_cmd_t cmd,
    output pcich_sts_t      sts,
    output logic            m_valid,
    input  wire logic       m_ready,
    output pcich_out_t      m_data
);

    // Counter memories, one entry per cell.
    logic [COUNT_W-1:0] total_mem [NUM_CELLS];
    logic [COUNT_W-1:0] low_mem   [NUM_CELLS];
    logic [COUNT_W-1:0] med_mem   [NUM_CELLS];
    logic [COUNT_W-1:0] high_mem  [NUM_CELLS];

    // Ascending list of fire sizes.
    logic [SIZE_W-1:0]  size_mem  [MAX_SCENARIOS];

    pcich_in_t          item_reg;
    pcich_out_t         pend_reg;
    pcich_out_t         out_reg;
    logic               m_valid_reg;
    logic [CELL_AW-1:0] clr_addr_reg;
    logic [SCN_CW-1:0]  stored_reg;
    logic [SCN_AW-1:0]  ins_idx_reg;
    logic [SIZE_W-1:0]  size_rd_reg;
    logic [COUNT_W-1:0] total_rd_reg;
    logic [COUNT_W-1:0] low_rd_reg;
    logic [COUNT_W-1:0] med_rd_reg;
    logic [COUNT_W-1:0] high_rd_reg;

    logic [CELL_AW-1:0] cell_addr;
    logic [CELL_AW-1:0] cnt_addr;
    logic               in_range;
    logic [1:0]         band_sel;
    logic               band_err;
    logic [COUNT_W-1:0] bank_rd;
    logic [COUNT_W-1:0] total_inc;
    logic [COUNT_W-1:0] bank_inc;
    logic               tot_we;
    logic               low_we;
    logic               med_we;
    logic               high_we;
    logic [COUNT_W-1:0] tot_wd;
    logic [COUNT_W-1:0] bank_wd;
    pcich_out_t         cell_res;
    pcich_out_t         scn_res;

    assign cell_addr = item_reg.cell_index[CELL_AW-1:0];
    assign in_range  = (32'(item_reg.cell_index) < 32'(NUM_CELLS));
    assign cnt_addr  = cmd.clr_step ? clr_addr_reg : cell_addr;

    // Status back to the controller.
    assign sts.clr_last  = (clr_addr_reg == CELL_AW'(NUM_CELLS - 1));
    assign sts.is_scn    = (item_reg.cmd == CMD_SCN);
    assign sts.list_full = (stored_reg >= SCN_CW'(MAX_SCENARIOS));
    assign sts.at_zero   = (ins_idx_reg == '0);
    assign sts.found     = (size_rd_reg <= item_reg.fire_size);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Band classification of the held intensity.
    always_comb begin
        band_sel = BAND_NONE;
        band_err = 1'b0;
        if (cfg.record_bands) begin
            priority if (item_reg.intensity >= cfg.min_intensity
                         && item_reg.intensity <= cfg.low_band_top) begin
                band_sel = BAND_LOW;
            end else if (item_reg.intensity > cfg.low_band_top
                         && item_reg.intensity <= cfg.med_band_top) begin
                band_sel = BAND_MED;
            end else if (item_reg.intensity > cfg.med_band_top
                         && item_reg.intensity <= cfg.max_intensity) begin
                band_sel = BAND_HIGH;
            end else begin
                band_err = 1'b1;
            end
        end
    end

    // Saturating increments of the counts read for this cell.
    always_comb begin
        unique case (band_sel)
            BAND_LOW:  bank_rd = low_rd_reg;
            BAND_MED:  bank_rd = med_rd_reg;
            BAND_HIGH: bank_rd = high_rd_reg;
            default:   bank_rd = '0;
        endcase
        total_inc = (total_rd_reg == '1) ? total_rd_reg : total_rd_reg + 1'b1;
        bank_inc  = (bank_rd == '1) ? bank_rd : bank_rd + 1'b1;
    end

    // Memory write enables and data, shared with the clearing pass.
    always_comb begin
        tot_we  = cmd.clr_step || (cmd.cell_wr && in_range && !band_err);
        low_we  = cmd.clr_step || (cmd.cell_wr && in_range && band_sel == BAND_LOW);
        med_we  = cmd.clr_step || (cmd.cell_wr && in_range && band_sel == BAND_MED);
        high_we = cmd.clr_step || (cmd.cell_wr && in_range && band_sel == BAND_HIGH);
        tot_wd  = cmd.clr_step ? '0 : total_inc;
        bank_wd = cmd.clr_step ? '0 : bank_inc;
    end

    // Result of a cell item.
    always_comb begin
        cell_res                = '0;
        cell_res.status         = band_err && in_range ? STAT_OOB : STAT_OK;
        cell_res.band           = in_range ? band_sel : BAND_NONE;
        cell_res.scenario_count = stored_reg;
        if (in_range) begin
            cell_res.cell_total = band_err ? total_rd_reg : total_inc;
            cell_res.band_count = (band_sel != BAND_NONE) ? bank_inc : '0;
        end
    end

    // Result of a scenario end, either rejected by a full list or inserted.
    always_comb begin
        scn_res      = '0;
        scn_res.band = BAND_NONE;
        if (cmd.scn_full) begin
            scn_res.status         = STAT_FULL;
            scn_res.scenario_count = stored_reg;
        end else begin
            scn_res.status         = STAT_OK;
            scn_res.scenario_count = stored_reg + 1'b1;
            scn_res.size_rank      = ins_idx_reg;
        end
    end

    // Counter memories with registered read.
    always_ff @(posedge aclk) begin
        if (tot_we) begin
            total_mem[cnt_addr] <= tot_wd;
        end
        if (cmd.cell_rd) begin
            total_rd_reg <= total_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (low_we) begin
            low_mem[cnt_addr] <= bank_wd;
        end
        if (cmd.cell_rd) begin
            low_rd_reg <= low_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (med_we) begin
            med_mem[cnt_addr] <= bank_wd;
        end
        if (cmd.cell_rd) begin
            med_rd_reg <= med_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (high_we) begin
            high_mem[cnt_addr] <= bank_wd;
        end
        if (cmd.cell_rd) begin
            high_rd_reg <= high_mem[cell_addr];
        end
    end

    // Size list: entries move up one place at a time until the gap is found.
    always_ff @(posedge aclk) begin
        if (cmd.ins_shift) begin
            size_mem[ins_idx_reg] <= size_rd_reg;
        end else if (cmd.ins_put) begin
            size_mem[ins_idx_reg] <= item_reg.fire_size;
        end
        if (cmd.ins_read) begin
            size_rd_reg <= size_mem[ins_idx_reg - 1'b1];
        end
    end

    // Control counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            stored_reg   <= '0;
            ins_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.capture) begin
                ins_idx_reg <= stored_reg[SCN_AW-1:0];
            end else if (cmd.ins_shift) begin
                ins_idx_reg <= ins_idx_reg - 1'b1;
            end
            if (cmd.ins_put) begin
                stored_reg <= stored_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item hold, pending result and output register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.cell_wr) begin
            pend_reg <= cell_res;
        end else if (cmd.scn_full || cmd.ins_put) begin
            pend_reg <= scn_res;
        end
        if (cmd.out_load) begin
            out_reg <= pend_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/per_cell_intensity_class_histogram.sv @@
// Top level of the per-cell intensity class histogram.
// Depends on pcich_pkg, pcich_regs, pcich_ctrl and pcich_dp.
//
//   Channel  Direction  Handshake           Beat
//   s_       in         s_valid / s_ready   pcich_in_t  (cell item or scenario end)
//   m_       out        m_valid / m_ready   pcich_out_t (one result per item)
//   APB      in         psel / penable      32-bit register write or read
//
// A cell item is read from the four counter memories and then written
// back, one read-then-write pass per item; its result then waits in the
// pending register until the output register is free.
// A scenario end moves each stored size that is above the new one up one
// place through the list port, then puts the new size into the gap; a full
// list answers without changing the list.
// After reset, a clearing pass zeroes all 65536 entries of each counter
// memory, during which s_ready stays low. A stalled result waits in the output
// register while the next beat is accepted and worked on; that item then
// waits in its final state, with s_ready low, until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module per_cell_intensity_class_histogram
    import pcich_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pcich_in_t         s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pcich_out_t             m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [REG_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    pcich_cfg_t cfg;
    pcich_cmd_t cmd;
    pcich_sts_t sts;

    // Configuration registers.
    pcich_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller.
    pcich_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath.
    pcich_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // One item at a time: the block is busy the cycle after an accepted beat.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    // A result is only loaded when the output register is free.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while stalled");

    // The stored size count never passes the list depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.scenario_count <= SCN_CW'(MAX_SCENARIOS)))
        else $error("scenario count beyond list depth");

    // An out-of-band intensity never reports a band.
    a_oob_no_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_OOB) |-> (m_data.band == BAND_NONE))
        else $error("out-of-band result carries a band");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the per-cell intensity class histogram.
// Depends on pcich_pkg and per_cell_intensity_class_histogram; no other files.
`timescale 1ns / 1ps

module tb;
    import pcich_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [INT_W-1:0] INT_MAX = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pcich_in_t         s_data;
    logic              m_valid;
    logic              m_ready;
    pcich_out_t        m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [REG_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    per_cell_intensity_class_histogram DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the block's counters, size list and band settings.
    bit [COUNT_W-1:0] total_mirror [NUM_CELLS];
    bit [COUNT_W-1:0] low_mirror   [NUM_CELLS];
    bit [COUNT_W-1:0] med_mirror   [NUM_CELLS];
    bit [COUNT_W-1:0] high_mirror  [NUM_CELLS];
    bit [SIZE_W-1:0]  size_list [$];
    pcich_cfg_t       band_cfg;

    // Results still owed by the block, oldest first.
    pcich_out_t       owed_results [$];

    int               err_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               n_items;
    int               n_scenarios;
    int               n_oob;
    int               n_full;
    int               n_saturated;
    logic [CELL_W-1:0] hot_cells [8];

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run-away guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic bit [COUNT_W-1:0] sat_bump(input bit [COUNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Works out the result of one accepted beat and updates the mirror.
    function automatic pcich_out_t histogram_result(input pcich_in_t it);
        pcich_out_t       r;
        logic [1:0]       band;
        logic [INT_W-1:0] v;
        int               c;
        int               pos;
        r = '0;
        r.status = STAT_OK;
        r.band = BAND_NONE;
        if (it.cmd == CMD_CELL) begin
            c = int'(it.cell_index);
            v = it.intensity;
            if (v >= band_cfg.min_intensity && v <= band_cfg.low_band_top)
                band = BAND_LOW;
            else if (v > band_cfg.low_band_top && v <= band_cfg.med_band_top)
                band = BAND_MED;
            else if (v > band_cfg.med_band_top && v <= band_cfg.max_intensity)
                band = BAND_HIGH;
            else
                band = BAND_NONE;
            if (band_cfg.record_bands && band == BAND_NONE) begin
                // Out of every band: nothing counted, total reported as it stands.
                r.status = STAT_OOB;
                r.cell_total = total_mirror[c];
            end else begin
                total_mirror[c] = sat_bump(total_mirror[c]);
                r.cell_total = total_mirror[c];
                if (band_cfg.record_bands) begin
                    r.band = band;
                    case (band)
                        BAND_LOW: begin
                            low_mirror[c] = sat_bump(low_mirror[c]);
                            r.band_count = low_mirror[c];
                        end
                        BAND_MED: begin
                            med_mirror[c] = sat_bump(med_mirror[c]);
                            r.band_count = med_mirror[c];
                        end
                        default: begin
                            high_mirror[c] = sat_bump(high_mirror[c]);
                            r.band_count = high_mirror[c];
                        end
                    endcase
                end
            end
        end else if (size_list.size() >= MAX_SCENARIOS) begin
            r.status = STAT_FULL;
        end else begin
            // Insert after every stored size that is less than or equal.
            pos = 0;
            while (pos < size_list.size() && size_list[pos] <= it.fire_size)
                pos++;
            size_list.insert(pos, it.fire_size);
            r.size_rank = pos[SCN_AW-1:0];
        end
        r.scenario_count = SCN_CW'(size_list.size());
        return r;
    endfunction

    // Result checker: each beat out is compared with the oldest owed result.
    always @(posedge aclk) begin : check_result
        pcich_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("Cycle %0d: result beat with nothing owed: %p",
                             cycle_count, m_data);
            end else begin
                want = owed_results.pop_front();
                if (m_data.status !== want.status || m_data.band !== want.band ||
                    m_data.cell_total !== want.cell_total ||
                    m_data.band_count !== want.band_count ||
                    m_data.scenario_count !== want.scenario_count ||
                    m_data.size_rank !== want.size_rank) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("Cycle %0d: mismatch", cycle_count);
                        $display("  expected status=%0d band=%0d total=%0d bcount=%0d scn=%0d rank=%0d",
                                 want.status, want.band, want.cell_total,
                                 want.band_count, want.scenario_count, want.size_rank);
                        $display("  actual   status=%0d band=%0d total=%0d bcount=%0d scn=%0d rank=%0d",
                                 m_data.status, m_data.band, m_data.cell_total,
                                 m_data.band_count, m_data.scenario_count, m_data.size_rank);
                    end
                end
            end
        end
    end

    // Sends one beat; entered and left at a falling edge.
    task automatic send_item(input pcich_in_t it);
        pcich_out_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = histogram_result(it);
        owed_results.insert(owed_results.size(), r);
        n_items++;
        if (it.cmd == CMD_SCN)
            n_scenarios++;
        if (r.status == STAT_OOB)
            n_oob++;
        if (r.status == STAT_FULL)
            n_full++;
        if (it.cmd == CMD_CELL && r.cell_total == '1)
            n_saturated++;
        @(negedge aclk);
    endtask

    // Lets the block run dry so that the registers may be rewritten.
    task automatic drain();
        s_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One APB write: setup cycle then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_INT:  band_cfg.min_intensity = val[INT_W-1:0];
            REG_LOW_TOP:  band_cfg.low_band_top = val[INT_W-1:0];
            REG_MED_TOP:  band_cfg.med_band_top = val[INT_W-1:0];
            REG_MAX_INT:  band_cfg.max_intensity = val[INT_W-1:0];
            REG_REC_BAND: band_cfg.record_bands = val[0];
            default: ;
        endcase
    endtask

    task automatic set_bands(input logic [INT_W-1:0] lo, input logic [INT_W-1:0] low_top,
                             input logic [INT_W-1:0] med_top, input logic [INT_W-1:0] hi,
                             input logic rec);
        write_reg(REG_MIN_INT, APB_DW'(lo));
        write_reg(REG_LOW_TOP, APB_DW'(low_top));
        write_reg(REG_MED_TOP, APB_DW'(med_top));
        write_reg(REG_MAX_INT, APB_DW'(hi));
        write_reg(REG_REC_BAND, APB_DW'(rec));
    endtask

    // Cell beat; the unused size field carries random bits.
    function automatic pcich_in_t cell_beat(input logic [CELL_W-1:0] cell_idx,
                                            input logic [INT_W-1:0] v);
        pcich_in_t it;
        it.cmd = CMD_CELL;
        it.cell_index = cell_idx;
        it.intensity = v;
        it.fire_size = $urandom;
        return it;
    endfunction

    // Scenario-end beat; the unused cell fields carry random bits.
    function automatic pcich_in_t scenario_beat(input logic [SIZE_W-1:0] size);
        pcich_in_t it;
        it.cmd = CMD_SCN;
        it.cell_index = CELL_W'($urandom);
        it.intensity = INT_W'($urandom);
        it.fire_size = size;
        return it;
    endfunction

    // Default bands, both extremes of the fields, and a run of fire sizes
    // with a duplicate.
    task automatic test_default_bands();
        send_item(cell_beat(16'h0000, 20'd0));
        send_item(cell_beat(16'h0000, 20'd2000));
        send_item(cell_beat(16'h0000, 20'd2001));
        send_item(cell_beat(16'hFFFF, 20'd4000));
        send_item(cell_beat(16'hFFFF, 20'd4001));
        send_item(cell_beat(16'hFFFF, INT_MAX));
        send_item(cell_beat(16'h5555, 20'hAAAAA));
        send_item(scenario_beat(32'h8000_0000));
        send_item(scenario_beat(32'h0000_0000));
        send_item(scenario_beat(SIZE_MAX));
        send_item(scenario_beat(32'h8000_0000));
        send_item(scenario_beat(32'h0000_0001));
        drain();
    endtask

    // Each band edge on both sides, then counting with bands switched off.
    task automatic test_band_edges();
        set_bands(20'd100, 20'd200, 20'd300, 20'd400, 1'b1);
        send_item(cell_beat(16'h00FF, 20'd99));
        send_item(cell_beat(16'h00FF, 20'd100));
        send_item(cell_beat(16'h00FF, 20'd200));
        send_item(cell_beat(16'h00FF, 20'd201));
        send_item(cell_beat(16'h00FF, 20'd300));
        send_item(cell_beat(16'h00FF, 20'd301));
        send_item(cell_beat(16'h00FF, 20'd400));
        send_item(cell_beat(16'h00FF, 20'd401));
        send_item(cell_beat(16'h00FF, INT_MAX));
        drain();
        write_reg(REG_REC_BAND, '0);
        send_item(cell_beat(16'h00FF, 20'd0));
        send_item(cell_beat(16'h00FF, INT_MAX));
        drain();
    endtask

    // Hits one cell over and over across all three bands.
    task automatic test_repeat_hits();
        set_bands(20'd0, 20'd2000, 20'd4000, INT_MAX, 1'b1);
        for (int i = 0; i < 16; i++)
            send_item(cell_beat(16'h1234, INT_W'($urandom_range(0, 6000))));
        drain();
    endtask

    // Chooses a band setting: ordered, degenerate, scrambled or disabled.
    task automatic pick_bands();
        logic [INT_W-1:0] a;
        logic [INT_W-1:0] b;
        logic [INT_W-1:0] c;
        logic [INT_W-1:0] d;
        a = INT_W'($urandom_range(0, 4000));
        b = a + INT_W'($urandom_range(0, 4000));
        c = b + INT_W'($urandom_range(0, 4000));
        d = c + INT_W'($urandom_range(0, INT_MAX - c));
        case ($urandom_range(5))
            0, 1: set_bands(a, b, c, d, 1'b1);
            2:    set_bands('0, '0, '0, '0, 1'b1);
            3:    set_bands(INT_MAX, INT_MAX, INT_MAX, INT_MAX, 1'b1);
            4:    set_bands(INT_W'($urandom), INT_W'($urandom), INT_W'($urandom),
                            INT_W'($urandom), 1'($urandom_range(1)));
            default: set_bands(a, b, c, d, 1'b0);
        endcase
    endtask

    function automatic pcich_in_t random_beat();
        logic [CELL_W-1:0] cell_idx;
        logic [INT_W-1:0]  v;
        logic [SIZE_W-1:0] size;
        int                pick;
        if ($urandom_range(99) < 30) begin
            pick = $urandom_range(9);
            if (pick < 4)
                size = $urandom;
            else if (pick < 6 && size_list.size() > 0)
                size = size_list[$urandom_range(size_list.size() - 1)];
            else if (pick < 8)
                size = $urandom_range(0, 1000);
            else
                size = (pick == 8) ? '0 : SIZE_MAX;
            return scenario_beat(size);
        end
        cell_idx = ($urandom_range(99) < 70) ? hot_cells[3'($urandom_range(7))]
                                              : CELL_W'($urandom);
        // Half the intensities sit on or next to a band edge.
        if ($urandom_range(1)) begin
            case ($urandom_range(3))
                0: v = band_cfg.min_intensity;
                1: v = band_cfg.low_band_top;
                2: v = band_cfg.med_band_top;
                default: v = band_cfg.max_intensity;
            endcase
            v = v + INT_W'($urandom_range(2)) - 1'b1;
        end else if ($urandom_range(1)) begin
            v = INT_W'($urandom_range(0, 8000));
        end else begin
            v = INT_W'($urandom);
        end
        return cell_beat(cell_idx, v);
    endfunction

    // Random traffic under each idling pattern, two band settings apiece.
    task automatic test_random_traffic();
        int sender_pcts [4];
        int receiver_pcts [4];
        sender_pcts = '{0, 85, 0, 38};
        receiver_pcts = '{0, 0, 85, 38};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = sender_pcts[p];
            recv_stall_pct = receiver_pcts[p];
            for (int s = 0; s < 2; s++) begin
                pick_bands();
                for (int i = 0; i < 127; i++)
                    send_item(random_beat());
                drain();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_items = 0;
        n_scenarios = 0;
        n_oob = 0;
        n_full = 0;
        n_saturated = 0;
        band_cfg.min_intensity = 20'd0;
        band_cfg.low_band_top = 20'd2000;
        band_cfg.med_band_top = 20'd4000;
        band_cfg.max_intensity = INT_MAX;
        band_cfg.record_bands = 1'b1;
        hot_cells[0] = 16'h0000;
        hot_cells[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            hot_cells[i] = CELL_W'($urandom);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_bands();
        test_band_edges();
        test_repeat_hits();
        test_random_traffic();

        drain();
        if (owed_results.size() != 0)
            err_count += owed_results.size();

        $display("Sent %0d beats: %0d scenario ends, %0d rejected by a full list.",
                 n_items, n_scenarios, n_full);
        $display("Out-of-band intensities: %0d; results at a saturated total: %0d.",
                 n_oob, n_saturated);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pcich_pkg.sv
rtl/core/pcich_regs.sv
rtl/core/pcich_ctrl.sv
rtl/core/pcich_dp.sv
rtl/core/per_cell_intensity_class_histogram.sv
tb/tb.sv
